// ----- rtl/spifcs_pkg.sv -----
// Package with the shared types and codes of the SPI flash command sequencer.
`default_nettype none
package spifcs_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_HOST_BYTE = 2'd1;
  localparam logic [1:0] OP_LINE_BYTE = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_TARGET = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_WRITE_IDLE_LIMIT = 2'd0;
  localparam logic [1:0] REG_READ_IDLE_LIMIT = 2'd1;

  localparam logic [15:0] WRITE_IDLE_LIMIT_RESET = 16'h0100;
  localparam logic [15:0] READ_IDLE_LIMIT_RESET = 16'h1000;

  // Result slots of a job, in the order in which they go out.
  localparam int SLOT_FIRST = 0;
  localparam int SLOT_ADDR_HIGH = 1;
  localparam int SLOT_ADDR_MID = 2;
  localparam int SLOT_ADDR_LOW = 3;
  localparam int SLOT_DUMMY = 4;
  localparam int SLOT_FILLER = 5;
  localparam int SLOT_READ = 6;
  localparam int SLOT_END = 7;
  localparam int NUM_SLOTS = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  command_code;
    logic        with_address;
    logic [23:0] flash_address;
    logic        with_dummy;
    logic        read_mode;
    logic [15:0] data_count;
    logic [3:0]  target;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [3:0] select_mask;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [7:0]           data;
    logic [23:0]          addr;
    logic [3:0]           mask;
    logic [1:0]           status;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/spifcs_front.sv -----
// Front part: accepts items, keeps the command state and turns each item that yields result slots into a job.
`default_nettype none
module spifcs_front #(
  parameter int NUM_TARGETS = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  spifcs_pkg::item_t    item,
  input  wire                  cfg_write,
  input  wire [1:0]            cfg_index,
  input  wire [15:0]           cfg_data,
  output logic                 job_push,
  output spifcs_pkg::job_t     job
);
  import spifcs_pkg::*;

  logic [15:0] write_idle_limit;
  logic [15:0] read_idle_limit;
  logic        busy, busy_next;
  logic        receiving, receiving_next;
  logic [2:0]  skip_left, skip_left_next;
  logic [15:0] data_left, data_left_next;
  logic [15:0] filler_left, filler_left_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [3:0]  active_mask, active_mask_next;

  logic [15:0] data_dec;
  logic [15:0] limit;
  logic        finish;
  logic        target_ok;

  assign data_dec = data_left - 16'd1;
  assign limit = receiving ? read_idle_limit : write_idle_limit;
  assign target_ok = {1'b0, item.target} < 5'(NUM_TARGETS);

  always_comb begin
    busy_next = busy;
    receiving_next = receiving;
    skip_left_next = skip_left;
    data_left_next = data_left;
    filler_left_next = filler_left;
    idle_ticks_next = idle_ticks;
    active_mask_next = active_mask;
    finish = 1'b0;
    job.slots = '0;
    job.data = item.data_byte;
    job.addr = item.flash_address;
    job.mask = active_mask;
    job.status = STATUS_OK;
    case (item.op)
      OP_START: begin
        if (!busy) begin
          if (!target_ok) begin
            job.slots[SLOT_END] = 1'b1;
            job.status = STATUS_BAD_TARGET;
          end else begin
            active_mask_next = 4'(1 << item.target);
            job.mask = 4'(1 << item.target);
            job.data = item.command_code;
            busy_next = 1'b1;
            receiving_next = item.read_mode;
            idle_ticks_next = '0;
            job.slots[SLOT_FIRST] = 1'b1;
            job.slots[SLOT_ADDR_HIGH] = item.with_address;
            job.slots[SLOT_ADDR_MID] = item.with_address;
            job.slots[SLOT_ADDR_LOW] = item.with_address;
            job.slots[SLOT_DUMMY] = item.with_dummy;
            data_left_next = item.data_count;
            if (item.data_count == '0) begin
              job.slots[SLOT_END] = 1'b1;
              finish = 1'b1;
            end else if (item.read_mode) begin
              skip_left_next = 3'd1 + (item.with_address ? 3'd3 : 3'd0)
                               + (item.with_dummy ? 3'd1 : 3'd0);
              filler_left_next = item.data_count - 16'd1;
              job.slots[SLOT_FILLER] = 1'b1;
            end else begin
              skip_left_next = '0;
              filler_left_next = '0;
            end
          end
        end
      end
      OP_HOST_BYTE: begin
        if (busy && !receiving) begin
          idle_ticks_next = '0;
          job.slots[SLOT_FIRST] = 1'b1;
          data_left_next = data_dec;
          if (data_dec == '0) begin
            job.slots[SLOT_END] = 1'b1;
            finish = 1'b1;
          end
        end
      end
      OP_LINE_BYTE: begin
        if (busy && receiving) begin
          idle_ticks_next = '0;
          if (filler_left != '0) begin
            filler_left_next = filler_left - 16'd1;
            job.slots[SLOT_FILLER] = 1'b1;
          end
          if (skip_left != '0) begin
            skip_left_next = skip_left - 3'd1;
          end else begin
            job.slots[SLOT_READ] = 1'b1;
            data_left_next = data_dec;
            if (data_dec == '0) begin
              job.slots[SLOT_END] = 1'b1;
              finish = 1'b1;
            end
          end
        end
      end
      default: begin
        if (busy) begin
          if (idle_ticks >= limit) begin
            job.slots[SLOT_END] = 1'b1;
            job.status = STATUS_TIMEOUT;
            finish = 1'b1;
          end else begin
            idle_ticks_next = idle_ticks + 16'd1;
          end
        end
      end
    endcase
    if (finish) begin
      busy_next = 1'b0;
      receiving_next = 1'b0;
      skip_left_next = '0;
      data_left_next = '0;
      filler_left_next = '0;
      idle_ticks_next = '0;
      active_mask_next = '0;
    end
  end

  assign job_push = accept && (job.slots != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      receiving <= 1'b0;
      skip_left <= '0;
      data_left <= '0;
      filler_left <= '0;
      idle_ticks <= '0;
      active_mask <= '0;
    end else if (accept) begin
      busy <= busy_next;
      receiving <= receiving_next;
      skip_left <= skip_left_next;
      data_left <= data_left_next;
      filler_left <= filler_left_next;
      idle_ticks <= idle_ticks_next;
      active_mask <= active_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_idle_limit <= WRITE_IDLE_LIMIT_RESET;
      read_idle_limit <= READ_IDLE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WRITE_IDLE_LIMIT: write_idle_limit <= cfg_data;
        REG_READ_IDLE_LIMIT: read_idle_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spifcs_queue.sv -----
// Short job queue between the front and back parts.
`default_nettype none
module spifcs_queue #(
  parameter int DEPTH = 4
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  spifcs_pkg::job_t  push_job,
  output logic              full,
  input  wire               pop,
  output logic              empty,
  output spifcs_pkg::job_t  head
);
  import spifcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full = count == CW'(DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spifcs_back.sv -----
// Back part: expands each job into result beats, one beat per cycle while the output register is free or popped.
`default_nettype none
module spifcs_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  job_ready,
  input  spifcs_pkg::job_t     job,
  output logic                 job_take,
  output logic                 empty,
  input  wire                  pop,
  output spifcs_pkg::result_t  result
);
  import spifcs_pkg::*;

  job_t                 cur;
  logic [NUM_SLOTS-1:0] low;
  logic [NUM_SLOTS-1:0] rest;
  logic                 out_valid;
  logic                 fire;
  result_t              beat;

  assign low = cur.slots & (~cur.slots + NUM_SLOTS'(1));
  assign rest = cur.slots & ~low;
  assign fire = (cur.slots != '0) && (!out_valid || pop);
  assign job_take = job_ready && ((cur.slots == '0) || (fire && rest == '0));
  assign empty = !out_valid;

  always_comb begin
    beat.kind = KIND_LINE;
    beat.byte_value = '0;
    beat.select_mask = cur.mask;
    beat.status = STATUS_OK;
    beat.last = rest == '0;
    case (low)
      NUM_SLOTS'(1) << SLOT_FIRST: beat.byte_value = cur.data;
      NUM_SLOTS'(1) << SLOT_ADDR_HIGH: beat.byte_value = cur.addr[23:16];
      NUM_SLOTS'(1) << SLOT_ADDR_MID: beat.byte_value = cur.addr[15:8];
      NUM_SLOTS'(1) << SLOT_ADDR_LOW: beat.byte_value = cur.addr[7:0];
      NUM_SLOTS'(1) << SLOT_READ: begin
        beat.kind = KIND_READ;
        beat.byte_value = cur.data;
      end
      NUM_SLOTS'(1) << SLOT_END: begin
        beat.kind = KIND_END;
        beat.select_mask = '0;
        beat.status = cur.status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.slots <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        cur.slots <= job.slots;
        cur.data <= job.data;
        cur.addr <= job.addr;
        cur.mask <= job.mask;
        cur.status <= job.status;
      end else if (fire) begin
        cur.slots <= rest;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= beat;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spi_flash_command_sequencer_core.sv -----
// SPI flash command sequencer: front part, job queue and back part.
// Items are taken at one per cycle while the job queue has room.
// The first beat of an item passes through the job queue, the back part's current job and the output register.
// The back part sends one beat per cycle while results are popped; a start with full header gives up to six beats.
// Synchronous reset clears the command state, the queue, the back part's current job and output valid flag, and
// restores the idle limits to their reset values.
`default_nettype none
module spi_flash_command_sequencer_core #(
  parameter int NUM_TARGETS = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  spifcs_pkg::item_t    item,
  output logic                 empty,
  input  wire                  pop,
  output spifcs_pkg::result_t  result,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [15:0]           cfg_data
);
  import spifcs_pkg::*;

  logic job_push, job_take, queue_empty;
  job_t new_job, head_job;

  assign cfg_ready = 1'b1;

  spifcs_front #(
    .NUM_TARGETS(NUM_TARGETS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(push && !full),
    .item(item),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .job_push(job_push),
    .job(new_job)
  );

  spifcs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .push_job(new_job),
    .full(full),
    .pop(job_take),
    .empty(queue_empty),
    .head(head_job)
  );

  spifcs_back u_back (
    .clk(clk),
    .rst(rst),
    .job_ready(!queue_empty),
    .job(head_job),
    .job_take(job_take),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

endmodule
`default_nettype wire

// ----- tb/spi_flash_command_sequencer_checker.sv -----
// Watches the channels of the command sequencer, predicts every result beat and compares it.
`timescale 1ns / 100ps
module spi_flash_command_sequencer_checker #(
  parameter int NUM_TARGETS = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire                  full,
  input  spifcs_pkg::item_t    item,
  input  wire                  empty,
  input  wire                  pop,
  input  spifcs_pkg::result_t  result,
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [15:0]           cfg_data,
  output int                   fail_count,
  output int                   beats_pending,
  output int                   beats_checked,
  output int                   timeout_ends,
  output int                   bad_target_ends
);
  import spifcs_pkg::*;

  result_t beats_owed[$];
  result_t item_beats[$];

  logic        cmd_busy;
  logic        cmd_receiving;
  logic [2:0]  skip_cnt;
  logic [15:0] data_cnt;
  logic [15:0] filler_cnt;
  logic [15:0] idle_cnt;
  logic [3:0]  sel_mask;
  logic [15:0] write_limit;
  logic [15:0] read_limit;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %0s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d: %0s is %0h, expected %0h", beats_checked, name, got,
                                want));
    end
  endtask

  function automatic result_t make_beat(input logic [1:0] kind, input logic [7:0] value,
                                        input logic [3:0] mask, input logic [1:0] status);
    result_t r;
    r.kind = kind;
    r.byte_value = value;
    r.select_mask = mask;
    r.status = status;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic clear_command();
    cmd_busy = 1'b0;
    cmd_receiving = 1'b0;
    skip_cnt = '0;
    data_cnt = '0;
    filler_cnt = '0;
    idle_cnt = '0;
    sel_mask = '0;
  endtask

  task automatic close_command(input logic [1:0] st);
    item_beats.push_back(make_beat(KIND_END, 8'h00, 4'h0, st));
    clear_command();
  endtask

  task automatic advance_sequencer(input item_t it);
    logic [2:0]  hdr_len;
    logic [15:0] one_hot;
    logic [15:0] limit;
    result_t     tail;
    item_beats.delete();
    case (it.op)
      OP_START: begin
        if (!cmd_busy) begin
          if (it.target >= NUM_TARGETS) begin
            item_beats.push_back(make_beat(KIND_END, 8'h00, 4'h0, STATUS_BAD_TARGET));
          end else begin
            one_hot = 16'd1 << it.target;
            sel_mask = one_hot[3:0];
            cmd_busy = 1'b1;
            cmd_receiving = it.read_mode;
            idle_cnt = '0;
            hdr_len = 3'd1;
            item_beats.push_back(make_beat(KIND_LINE, it.command_code, sel_mask, STATUS_OK));
            if (it.with_address) begin
              item_beats.push_back(make_beat(KIND_LINE, it.flash_address[23:16], sel_mask,
                                             STATUS_OK));
              item_beats.push_back(make_beat(KIND_LINE, it.flash_address[15:8], sel_mask,
                                             STATUS_OK));
              item_beats.push_back(make_beat(KIND_LINE, it.flash_address[7:0], sel_mask,
                                             STATUS_OK));
              hdr_len = hdr_len + 3'd3;
            end
            if (it.with_dummy) begin
              item_beats.push_back(make_beat(KIND_LINE, 8'h00, sel_mask, STATUS_OK));
              hdr_len = hdr_len + 3'd1;
            end
            data_cnt = it.data_count;
            if (it.data_count == 16'd0) begin
              close_command(STATUS_OK);
            end else if (it.read_mode) begin
              skip_cnt = hdr_len;
              filler_cnt = it.data_count - 16'd1;
              item_beats.push_back(make_beat(KIND_LINE, 8'h00, sel_mask, STATUS_OK));
            end else begin
              skip_cnt = '0;
              filler_cnt = '0;
            end
          end
        end
      end
      OP_HOST_BYTE: begin
        if (cmd_busy && !cmd_receiving) begin
          idle_cnt = '0;
          item_beats.push_back(make_beat(KIND_LINE, it.data_byte, sel_mask, STATUS_OK));
          data_cnt = data_cnt - 16'd1;
          if (data_cnt == 16'd0) begin
            close_command(STATUS_OK);
          end
        end
      end
      OP_LINE_BYTE: begin
        if (cmd_busy && cmd_receiving) begin
          idle_cnt = '0;
          if (filler_cnt != 16'd0) begin
            filler_cnt = filler_cnt - 16'd1;
            item_beats.push_back(make_beat(KIND_LINE, 8'h00, sel_mask, STATUS_OK));
          end
          if (skip_cnt != 3'd0) begin
            skip_cnt = skip_cnt - 3'd1;
          end else begin
            item_beats.push_back(make_beat(KIND_READ, it.data_byte, sel_mask, STATUS_OK));
            data_cnt = data_cnt - 16'd1;
            if (data_cnt == 16'd0) begin
              close_command(STATUS_OK);
            end
          end
        end
      end
      default: begin
        if (cmd_busy) begin
          limit = cmd_receiving ? read_limit : write_limit;
          if (idle_cnt >= limit) begin
            close_command(STATUS_TIMEOUT);
          end else begin
            idle_cnt = idle_cnt + 16'd1;
          end
        end
      end
    endcase
    if (item_beats.size() > 0) begin
      tail = item_beats.pop_back();
      tail.last = 1'b1;
      item_beats.push_back(tail);
    end
    foreach (item_beats[i]) begin
      beats_owed.push_back(item_beats[i]);
    end
  endtask

  task automatic check_beat(input result_t got);
    result_t want;
    if (beats_owed.size() == 0) begin
      report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_checked));
    end else begin
      want = beats_owed.pop_front();
      check_field("kind", 8'(got.kind), 8'(want.kind));
      check_field("byte_value", got.byte_value, want.byte_value);
      check_field("select_mask", 8'(got.select_mask), 8'(want.select_mask));
      check_field("status", 8'(got.status), 8'(want.status));
      check_field("last", 8'(got.last), 8'(want.last));
      if (want.kind == KIND_END && want.status == STATUS_TIMEOUT) begin
        timeout_ends++;
      end
      if (want.kind == KIND_END && want.status == STATUS_BAD_TARGET) begin
        bad_target_ends++;
      end
    end
    beats_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_command();
      write_limit = WRITE_IDLE_LIMIT_RESET;
      read_limit = READ_IDLE_LIMIT_RESET;
      beats_owed.delete();
      fail_count = 0;
      beats_checked = 0;
      timeout_ends = 0;
      bad_target_ends = 0;
    end else begin
      if (pop && !empty) begin
        check_beat(result);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WRITE_IDLE_LIMIT: write_limit = cfg_data;
          REG_READ_IDLE_LIMIT: read_limit = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        advance_sequencer(item);
      end
    end
    beats_pending = beats_owed.size();
  end

endmodule

// ----- tb/spi_flash_command_sequencer_core_tb.sv -----
// Top of the testbench: drives commands, bytes and register writes into the sequencer.
`timescale 1ns / 100ps
module spi_flash_command_sequencer_core_tb;
  import spifcs_pkg::*;

  localparam int NUM_TARGETS = 4;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  item_t       item_bus = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result_bus;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int beats_pending;
  int beats_checked;
  int timeout_ends;
  int bad_target_ends;

  int          items_sent = 0;
  int          seq_items = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  logic [15:0] wr_limit_now = WRITE_IDLE_LIMIT_RESET;
  logic [15:0] rd_limit_now = READ_IDLE_LIMIT_RESET;
  int unsigned stall_cycles = 0;

  spi_flash_command_sequencer_core #(
    .NUM_TARGETS(NUM_TARGETS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item_bus),
    .empty(empty),
    .pop(pop),
    .result(result_bus),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  spi_flash_command_sequencer_checker #(
    .NUM_TARGETS(NUM_TARGETS)
  ) seq_check (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item_bus),
    .empty(empty),
    .pop(pop),
    .result(result_bus),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .beats_pending(beats_pending),
    .beats_checked(beats_checked),
    .timeout_ends(timeout_ends),
    .bad_target_ends(bad_target_ends)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 31);
      end
    end
  end

  function automatic item_t random_fields();
    item_t it;
    it.op = 2'($urandom);
    it.command_code = 8'($urandom);
    it.with_address = 1'($urandom);
    it.flash_address = 24'($urandom);
    it.with_dummy = 1'($urandom);
    it.read_mode = 1'($urandom);
    it.data_count = 16'($urandom);
    it.target = 4'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic item_t start_item(input logic [7:0] code, input logic with_addr,
                                       input logic [23:0] addr, input logic with_dummy,
                                       input logic rd, input logic [15:0] count,
                                       input logic [3:0] tgt);
    item_t it;
    it = random_fields();
    it.op = OP_START;
    it.command_code = code;
    it.with_address = with_addr;
    it.flash_address = addr;
    it.with_dummy = with_dummy;
    it.read_mode = rd;
    it.data_count = count;
    it.target = tgt;
    return it;
  endfunction

  function automatic item_t byte_item(input logic [1:0] op, input logic [7:0] data);
    item_t it;
    it = random_fields();
    it.op = op;
    it.data_byte = data;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while (!no_idle && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(input logic [15:0] wr, input logic [15:0] rd,
                              input bit poke_unmapped);
    logic [1:0]  idx [3];
    logic [15:0] val [3];
    int          n;
    idx[0] = REG_WRITE_IDLE_LIMIT;
    val[0] = wr;
    idx[1] = REG_READ_IDLE_LIMIT;
    val[1] = rd;
    idx[2] = REG_UNMAPPED;
    val[2] = 16'hFFFF;
    n = poke_unmapped ? 3 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    wr_limit_now = wr;
    rd_limit_now = rd;
  endtask

  // One start followed by its data bytes, now and then cut short and closed by idle ticks.
  task automatic run_command(input bit allow_big);
    item_t       it;
    int unsigned hdr_len;
    int unsigned body_len;
    int unsigned roll;
    int unsigned lim;
    bit          bad_tgt;
    bit          cut;
    it = random_fields();
    it.op = OP_START;
    bad_tgt = ($urandom_range(9) == 0);
    it.target = bad_tgt ? 4'($urandom_range(15, NUM_TARGETS)) : 4'($urandom_range(NUM_TARGETS - 1));
    lim = it.read_mode ? rd_limit_now : wr_limit_now;
    roll = $urandom_range(99);
    if (roll < 8) begin
      it.data_count = '0;
    end else if (roll < 85) begin
      it.data_count = 16'($urandom_range(6, 1));
    end else if (roll < 95 || !allow_big || lim > 16) begin
      it.data_count = 16'($urandom_range(40, 7));
    end else begin
      it.data_count = 16'($urandom);
    end
    send_item(it);
    seq_items++;
    if (bad_tgt) begin
      return;
    end
    hdr_len = 1 + (it.with_address ? 3 : 0) + (it.with_dummy ? 1 : 0);
    body_len = it.data_count + ((it.read_mode && it.data_count != 0) ? hdr_len : 0);
    cut = (lim <= 16) && ($urandom_range(7) == 0 || body_len > 48);
    if (cut) begin
      body_len = $urandom_range(body_len < 48 ? body_len : 48);
    end
    for (int i = 0; i < body_len; i++) begin
      if ($urandom_range(99) < 8) begin
        send_item(byte_item(OP_TICK, 8'($urandom)));
      end
      send_item(byte_item(it.read_mode ? OP_LINE_BYTE : OP_HOST_BYTE, 8'($urandom)));
      seq_items++;
    end
    if (cut) begin
      repeat (lim + 1) send_item(byte_item(OP_TICK, 8'($urandom)));
    end
  endtask

  task automatic random_phase(input int n_items, input bit allow_big);
    int   seq_base;
    item_t noise;
    seq_base = seq_items;
    while (seq_items - seq_base < n_items) begin
      if ($urandom_range(99) < 15) begin
        noise = random_fields();
        noise.data_count = noise.data_count & 16'h000F;
        send_item(noise);
      end else begin
        run_command(allow_big);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limits.
    send_item(byte_item(OP_TICK, 8'h00));
    send_item(byte_item(OP_HOST_BYTE, 8'hFF));
    send_item(byte_item(OP_LINE_BYTE, 8'hFF));
    send_item(start_item(8'h00, 1'b0, 24'h000000, 1'b0, 1'b0, 16'd1, 4'd4));
    send_item(start_item(8'hFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b1, 16'hFFFF, 4'd15));
    send_item(start_item(8'hFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b0, 16'd2, 4'd0));
    send_item(start_item(8'h03, 1'b0, 24'h000000, 1'b0, 1'b1, 16'd1, 4'd1));
    send_item(byte_item(OP_LINE_BYTE, 8'h11));
    send_item(byte_item(OP_TICK, 8'h00));
    send_item(byte_item(OP_HOST_BYTE, 8'hFF));
    send_item(byte_item(OP_HOST_BYTE, 8'h00));
    send_item(start_item(8'h00, 1'b1, 24'h000000, 1'b0, 1'b1, 16'd0, 4'd3));
    send_item(start_item(8'h0B, 1'b1, 24'hA5C33C, 1'b1, 1'b1, 16'd2, 4'd1));
    send_item(byte_item(OP_HOST_BYTE, 8'h22));
    repeat (5) send_item(byte_item(OP_LINE_BYTE, 8'($urandom)));
    send_item(byte_item(OP_LINE_BYTE, 8'hFF));
    send_item(byte_item(OP_LINE_BYTE, 8'h00));
    send_item(start_item(8'h02, 1'b0, 24'h000000, 1'b0, 1'b0, 16'd1, 4'd2));
    send_item(byte_item(OP_HOST_BYTE, 8'h5A));
    drain();

    random_phase(80, 1'b0);
    drain();

    write_limits(16'h0000, 16'h0000, 1'b1);
    send_item(start_item(8'h03, 1'b1, 24'h800001, 1'b1, 1'b0, 16'hFFFF, 4'd3));
    send_item(byte_item(OP_HOST_BYTE, 8'hA5));
    send_item(byte_item(OP_TICK, 8'h00));
    send_item(start_item(8'h0B, 1'b0, 24'h000000, 1'b0, 1'b1, 16'hFFFF, 4'd0));
    send_item(byte_item(OP_TICK, 8'h00));
    random_phase(70, 1'b1);
    drain();

    write_limits(16'hFFFF, 16'hFFFF, 1'b0);
    hold_req = 1'b1;
    random_phase(80, 1'b0);
    drain();

    write_limits(16'd2, 16'd1, 1'b0);
    send_item(start_item(8'h02, 1'b0, 24'h000000, 1'b0, 1'b0, 16'd3, 4'd1));
    send_item(byte_item(OP_HOST_BYTE, 8'h3C));
    repeat (3) send_item(byte_item(OP_TICK, 8'h00));
    send_item(start_item(8'h03, 1'b0, 24'h000000, 1'b0, 1'b1, 16'd1, 4'd2));
    repeat (2) send_item(byte_item(OP_TICK, 8'h00));
    random_phase(70, 1'b1);
    drain();

    write_limits(16'($urandom_range(15)), 16'($urandom_range(15)), 1'b0);
    no_idle = 1'b1;
    random_phase(40, 1'b1);
    no_idle = 1'b0;
    random_phase(40, 1'b1);
    drain();

    $display("Covered %0d accepted items (%0d in command sequences), %0d result beats checked.",
             items_sent, seq_items, beats_checked);
    $display("Ends seen: %0d timeouts, %0d bad targets; idle limits swept 0 to 65535.",
             timeout_ends, bad_target_ends);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/spifcs_pkg.sv
rtl/spifcs_front.sv
rtl/spifcs_queue.sv
rtl/spifcs_back.sv
rtl/spi_flash_command_sequencer_core.sv
tb/spi_flash_command_sequencer_checker.sv
tb/spi_flash_command_sequencer_core_tb.sv
